FILE: rtl/ttvg_pkg.sv
// Shared types, constants and helpers of the torus triangle vertex generator.
`default_nettype none
package ttvg_pkg;

  localparam int MAX_DIVISIONS = 256;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int RAD_W  = 25;
  localparam int TRIG_W = 18;
  localparam int XY_W   = 27;
  localparam int Z_W    = 26;

  localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(MAX_DIVISIONS);
  localparam logic [RAD_W-1:0] RADIUS_MAX = 25'd16777216;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 25;
  localparam logic [CFG_INDEX_W-1:0] REG_MAJOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MINOR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RING  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TUBE  = 3'd3;

  localparam logic [RAD_W-1:0] MAJOR_RESET = 25'd65536;
  localparam logic [RAD_W-1:0] MINOR_RESET = 25'd16384;
  localparam logic [CNT_W-1:0] RING_RESET  = 9'd16;
  localparam logic [CNT_W-1:0] TUBE_RESET  = 9'd16;

  // cell queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // fixed point sine/cosine
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  typedef struct packed {
    logic [IDX_W-1:0] ring;
    logic [IDX_W-1:0] ring_next;
    logic [IDX_W-1:0] ring_prev;
    logic [IDX_W-1:0] tube;
    logic [IDX_W-1:0] tube_next;
    logic             bad;
  } cell_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic             ren;
    logic [IDX_W-1:0] ring_addr;
    logic [IDX_W-1:0] tube_addr;
  } tbl_req_t;

  // Taylor series divisors as reciprocals, innermost term first.
  // Each value is ceil(2^s / d) with s = 30 + ceil(log2 d), which gives the
  // exact floor quotient for any dividend below 2^30.
  function automatic logic [30:0] horner_recip(input logic cos_phase,
                                               input logic [2:0] k);
    logic [30:0] r;
    r = 31'h4000_0000;
    if (!cos_phase) begin
      case (k)
        3'd0:    r = 31'(((64'd1 << 37) + 64'd109) / 64'd110);
        3'd1:    r = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
        3'd2:    r = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
        3'd3:    r = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
        default: r = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
      endcase
    end else begin
      case (k)
        3'd0:    r = 31'(((64'd1 << 38) + 64'd131) / 64'd132);
        3'd1:    r = 31'(((64'd1 << 37) + 64'd89) / 64'd90);
        3'd2:    r = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
        3'd3:    r = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
        3'd4:    r = 31'(((64'd1 << 34) + 64'd11) / 64'd12);
        default: r = 31'h4000_0000;
      endcase
    end
    return r;
  endfunction

  // right shift that goes with horner_recip
  function automatic logic [5:0] horner_shift(input logic cos_phase,
                                              input logic [2:0] k);
    logic [5:0] s;
    s = 6'd31;
    if (!cos_phase) begin
      case (k)
        3'd0:    s = 6'd37;
        3'd1:    s = 6'd37;
        3'd2:    s = 6'd36;
        3'd3:    s = 6'd35;
        default: s = 6'd33;
      endcase
    end else begin
      case (k)
        3'd0:    s = 6'd38;
        3'd1:    s = 6'd37;
        3'd2:    s = 6'd36;
        3'd3:    s = 6'd35;
        3'd4:    s = 6'd34;
        default: s = 6'd31;
      endcase
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ttvg_if.sv
// Channel interfaces: cell input, vertex output and configuration writes.
`default_nettype none
interface ttvg_cell_if;
  import ttvg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] ring_index;
  logic [IDX_W-1:0] tube_index;
  modport source (output valid, ring_index, tube_index, input ready);
  modport sink   (input valid, ring_index, tube_index, output ready);
endinterface

interface ttvg_vertex_if;
  import ttvg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [XY_W-1:0] vertex_x;
  logic signed [XY_W-1:0] vertex_y;
  logic signed [Z_W-1:0]  vertex_z;
  logic                   bad_cell;
  logic                   last_vertex;
  modport source (output valid, vertex_x, vertex_y, vertex_z, bad_cell, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, bad_cell, last_vertex,
                  output ready);
endinterface

interface ttvg_cfg_if;
  import ttvg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/torus_triangle_vertex_generator_top.sv
// Top level of the torus triangle vertex generator.
// Usage:
//   cell_in    : one item per grid cell (ring_index, tube_index).
//   vertex_out : six vertex items per good cell, last_vertex on the sixth;
//                a cell with an index at or past its count gives one item
//                with bad_cell and last_vertex set and zero coordinates.
//   cfg        : register writes (0 major radius, 1 minor radius,
//                2 ring count, 3 tube count); always ready.
// Throughput: one vertex per cycle while vertex_out does not stall, so a bad
//   cell every cycle; the single vertex pipeline sets this figure.
// An accepted cell passes through the cell queue, the issue register, the
//   s1 to s4 stages and the output register before its first vertex appears.
// Reset and count writes start a table sweep that computes sine and cosine
//   for every ring and tube division with one iterative unit; cell_in.ready
//   stays low during the sweep.
// When vertex_out stalls, the vertex pipeline holds; cells keep entering a
//   four-deep queue until it fills, then cell_in.ready drops.
`default_nettype none
module torus_triangle_vertex_generator_top import ttvg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ttvg_cfg_if.sink      cfg,
  ttvg_cell_if.sink     cell_in,
  ttvg_vertex_if.source vertex_out
);

  logic [RAD_W-1:0] major_radius;
  logic [RAD_W-1:0] minor_radius;
  logic [CNT_W-1:0] ring_count;
  logic [CNT_W-1:0] tube_count;
  logic [CNT_W-1:0] ring_n, tube_n;
  logic             cfg_wr;
  logic             rebuild;
  logic             tbl_ready;
  logic             pop;
  logic             head_valid;
  cell_t            head;
  tbl_req_t         req;
  trig_t            ring_rd, tube_rd;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  // count changes invalidate both tables
  assign rebuild   = cfg_wr && (cfg.index == REG_RING || cfg.index == REG_TUBE);

  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius <= MAJOR_RESET;
      minor_radius <= MINOR_RESET;
      ring_count   <= RING_RESET;
      tube_count   <= TUBE_RESET;
    end else if (cfg_wr) begin
      case (cfg.index)
        REG_MAJOR: major_radius <= cfg.data;
        REG_MINOR: minor_radius <= cfg.data;
        REG_RING:  ring_count   <= cfg.data[CNT_W-1:0];
        REG_TUBE:  tube_count   <= cfg.data[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // clamp counts to the table depth
  assign ring_n = (ring_count > COUNT_MAX) ? COUNT_MAX : ring_count;
  assign tube_n = (tube_count > COUNT_MAX) ? COUNT_MAX : tube_count;

  ttvg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cell_in    (cell_in),
    .ring_n     (ring_n),
    .tube_n     (tube_n),
    .tbl_ready  (tbl_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  ttvg_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rebuild (rebuild),
    .ring_n  (ring_n),
    .tube_n  (tube_n),
    .req     (req),
    .ring_rd (ring_rd),
    .tube_rd (tube_rd),
    .ready   (tbl_ready)
  );

  ttvg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .major_radius (major_radius),
    .minor_radius (minor_radius),
    .req          (req),
    .ring_rd      (ring_rd),
    .tube_rd      (tube_rd),
    .vertex_out   (vertex_out)
  );

endmodule
`default_nettype wire

FILE: rtl/ttvg_sincos.sv
// Iterative sine/cosine of a fraction of a turn, signed Q1.16 results (18 bits).
`default_nettype none
module ttvg_sincos import ttvg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] angle,
  input  logic [CNT_W-1:0] divs,
  output logic             done,
  output trig_t            result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_XDIV = 3'd1;
  localparam logic [2:0] S_X2   = 3'd2;
  localparam logic [2:0] S_HMUL = 3'd3;
  localparam logic [2:0] S_HDIV = 3'd4;
  localparam logic [2:0] S_SFIN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int DIV_W = 38;
  localparam logic [5:0] DIV_STEPS = 6'(DIV_W);

  logic [2:0]       state;
  logic [1:0]       quad;
  logic             swp;
  logic [30:0]      x;
  logic [30:0]      x2;
  logic [30:0]      acc;
  logic [30:0]      ts;
  logic             phase;
  logic [2:0]       k;
  logic [CNT_W-1:0] drem;
  logic [DIV_W-1:0] dq;
  logic [5:0]       dcnt;
  logic [CNT_W-1:0] dvs;

  // quadrant and remainder of 4*angle over divs
  logic [10:0]      four, n1, n2, n3, prem;
  logic [1:0]       pquad;
  logic             pswap;
  logic [CNT_W-1:0] pred;
  logic [38:0]      pnum;

  always_comb begin
    four = {1'b0, angle, 2'b00};
    n1   = {2'b00, divs};
    n2   = {1'b0, divs, 1'b0};
    n3   = n1 + n2;
    if (four >= n3) begin
      pquad = 2'd3;
      prem  = four - n3;
    end else if (four >= n2) begin
      pquad = 2'd2;
      prem  = four - n2;
    end else if (four >= n1) begin
      pquad = 2'd1;
      prem  = four - n1;
    end else begin
      pquad = 2'd0;
      prem  = four;
    end
    pswap = {prem[8:0], 1'b0} > {1'b0, divs};
    pred  = pswap ? (divs - prem[8:0]) : prem[8:0];
    pnum  = 39'(HALF_PI_Q30) * 39'(pred[7:0]) + 39'(divs[8:1]);
  end

  // one restoring division step
  logic [CNT_W:0]   dt, dsub;
  logic             dge;
  logic [CNT_W-1:0] drem_step;

  always_comb begin
    dt        = {drem, dq[DIV_W-1]};
    dge       = dt >= {1'b0, dvs};
    dsub      = dt - {1'b0, dvs};
    drem_step = dge ? dsub[CNT_W-1:0] : dt[CNT_W-1:0];
  end

  // Horner divisor as reciprocal and shift
  logic [30:0] hrecip;
  logic [5:0]  hshift;

  assign hrecip = horner_recip(phase, k);
  assign hshift = horner_shift(phase, k);

  // shared multiplier
  logic [30:0] mul_a, mul_b;
  logic [61:0] mprod;

  always_comb begin
    case (state)
      S_X2: begin
        mul_a = x;
        mul_b = x;
      end
      S_HDIV: begin
        mul_a = dq[30:0];
        mul_b = hrecip;
      end
      S_SFIN: begin
        mul_a = x;
        mul_b = ts;
      end
      default: begin
        mul_a = x2;
        mul_b = acc;
      end
    endcase
    mprod = 62'(mul_a) * 62'(mul_b);
  end

  logic [61:0] hq;
  logic [30:0] hnext;
  assign hq    = mprod >> hshift;
  assign hnext = ONE_Q30 - hq[30:0];

  // final rounding, octant swap and quadrant
  logic [30:0]              ts_r, tc_r;
  logic signed [TRIG_W-1:0] s_v, c_v, s_w, c_w;

  always_comb begin
    ts_r = ts + 31'd8192;
    tc_r = acc + 31'd8192;
    s_v  = {1'b0, ts_r[30:14]};
    c_v  = {1'b0, tc_r[30:14]};
    s_w  = swp ? c_v : s_v;
    c_w  = swp ? s_v : c_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            quad  <= pquad;
            swp   <= pswap;
            dq    <= pnum[DIV_W-1:0];
            drem  <= '0;
            dvs   <= divs;
            dcnt  <= DIV_STEPS;
            state <= S_XDIV;
          end
        end
        S_XDIV: begin
          if (dcnt != 6'd0) begin
            drem <= drem_step;
            dq   <= {dq[DIV_W-2:0], dge};
            dcnt <= dcnt - 6'd1;
          end else begin
            x     <= dq[30:0];
            state <= S_X2;
          end
        end
        S_X2: begin
          x2    <= mprod[60:30];
          acc   <= ONE_Q30;
          phase <= 1'b0;
          k     <= 3'd0;
          state <= S_HMUL;
        end
        S_HMUL: begin
          dq    <= DIV_W'(mprod[60:30]);
          state <= S_HDIV;
        end
        S_HDIV: begin
          if (!phase && k == 3'd4) begin
            // sine polynomial finished, start cosine
            ts    <= hnext;
            acc   <= ONE_Q30;
            phase <= 1'b1;
            k     <= 3'd0;
            state <= S_HMUL;
          end else if (phase && k == 3'd5) begin
            acc   <= hnext;
            state <= S_SFIN;
          end else begin
            acc   <= hnext;
            k     <= k + 3'd1;
            state <= S_HMUL;
          end
        end
        S_SFIN: begin
          ts    <= mprod[60:30];
          state <= S_OUT;
        end
        S_OUT: begin
          case (quad)
            2'd0: begin
              result.sin_v <= s_w;
              result.cos_v <= c_w;
            end
            2'd1: begin
              result.sin_v <= c_w;
              result.cos_v <= -s_w;
            end
            2'd2: begin
              result.sin_v <= -s_w;
              result.cos_v <= -c_w;
            end
            default: begin
              result.sin_v <= -c_w;
              result.cos_v <= s_w;
            end
          endcase
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ttvg_table.sv
// Ring and tube sine/cosine tables, rebuilt by a sweep after count changes.
`default_nettype none
module ttvg_table import ttvg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rebuild,
  input  logic [CNT_W-1:0] ring_n,
  input  logic [CNT_W-1:0] tube_n,
  input  tbl_req_t         req,
  output trig_t            ring_rd,
  output trig_t            tube_rd,
  output logic             ready
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_NEXT = 2'd1;
  localparam logic [1:0] T_WAIT = 2'd2;

  logic [1:0]       state;
  logic             dirty;
  logic             sel;
  logic [CNT_W-1:0] addr;
  logic [CNT_W-1:0] n_cur;
  logic             sc_start;
  logic             sc_done;
  trig_t            sc_res;

  trig_t ring_mem [MAX_DIVISIONS];
  trig_t tube_mem [MAX_DIVISIONS];

  assign n_cur    = sel ? tube_n : ring_n;
  assign sc_start = (state == T_NEXT) && !dirty && (addr < n_cur);
  assign ready    = (state == T_IDLE) && !dirty;

  ttvg_sincos u_sincos (
    .clk    (clk),
    .rst    (rst),
    .start  (sc_start),
    .angle  (addr[IDX_W-1:0]),
    .divs   (n_cur),
    .done   (sc_done),
    .result (sc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      dirty <= 1'b1;
      sel   <= 1'b0;
      addr  <= '0;
    end else begin
      if (rebuild) dirty <= 1'b1;
      case (state)
        T_IDLE: begin
          if (dirty) begin
            dirty <= rebuild;
            sel   <= 1'b0;
            addr  <= '0;
            state <= T_NEXT;
          end
        end
        T_NEXT: begin
          if (dirty) begin
            state <= T_IDLE;
          end else if (addr >= n_cur) begin
            if (!sel) begin
              sel  <= 1'b1;
              addr <= '0;
            end else begin
              state <= T_IDLE;
            end
          end else begin
            state <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (sc_done) begin
            addr  <= addr + 9'd1;
            state <= T_NEXT;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // drop results of a sweep that a newer count write has made stale
  always_ff @(posedge clk) begin
    if (state == T_WAIT && sc_done && !dirty) begin
      if (sel) tube_mem[addr[IDX_W-1:0]] <= sc_res;
      else     ring_mem[addr[IDX_W-1:0]] <= sc_res;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ren) begin
      ring_rd <= ring_mem[req.ring_addr];
      tube_rd <= tube_mem[req.tube_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ttvg_front.sv
// Front end: accept cells, check and wrap indices, queue them for the back end.
`default_nettype none
module ttvg_front import ttvg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  ttvg_cell_if.sink        cell_in,
  input  logic [CNT_W-1:0] ring_n,
  input  logic [CNT_W-1:0] tube_n,
  input  logic             tbl_ready,
  input  logic             pop,
  output cell_t            head,
  output logic             head_valid
);

  cell_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  cell_t             entry;
  logic [CNT_W-1:0]  ring_inc, tube_inc, ring_last;

  assign cell_in.ready = tbl_ready && (count != QCNT_W'(QUEUE_DEPTH));
  assign push          = cell_in.valid && cell_in.ready;
  assign head_valid    = count != '0;
  assign head          = q[rd_ptr];

  always_comb begin
    ring_inc        = {1'b0, cell_in.ring_index} + 9'd1;
    tube_inc        = {1'b0, cell_in.tube_index} + 9'd1;
    ring_last       = ring_n - 9'd1;
    entry.ring      = cell_in.ring_index;
    entry.tube      = cell_in.tube_index;
    entry.ring_next = (ring_inc == ring_n) ? '0 : ring_inc[IDX_W-1:0];
    entry.tube_next = (tube_inc == tube_n) ? '0 : tube_inc[IDX_W-1:0];
    entry.ring_prev = (cell_in.ring_index == '0) ? ring_last[IDX_W-1:0]
                                                 : cell_in.ring_index - 8'd1;
    entry.bad       = ({1'b0, cell_in.ring_index} >= ring_n) ||
                      ({1'b0, cell_in.tube_index} >= tube_n);
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ttvg_back.sv
// Back end: sequence six vertices per good cell (one per bad cell) and compute their coordinates.
`default_nettype none
module ttvg_back import ttvg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_t            head,
  input  logic             head_valid,
  output logic             pop,
  input  logic [RAD_W-1:0] major_radius,
  input  logic [RAD_W-1:0] minor_radius,
  output tbl_req_t         req,
  input  trig_t            ring_rd,
  input  trig_t            tube_rd,
  ttvg_vertex_if.source    vertex_out
);

  localparam logic [2:0] V_BASE       = 3'd0;
  localparam logic [2:0] V_RING_NEXT  = 3'd1;
  localparam logic [2:0] V_TUBE_NEXT  = 3'd2;
  localparam logic [2:0] V_BASE2      = 3'd3;
  localparam logic [2:0] V_TUBE_NEXT2 = 3'd4;
  localparam logic [2:0] V_DIAG       = 3'd5;

  logic en;
  logic fire;
  logic [2:0] kcnt;

  logic             iss_valid, iss_bad, iss_last;
  logic [IDX_W-1:0] iss_a, iss_b;
  logic [IDX_W-1:0] sel_a, sel_b;

  logic s1_valid, s1_bad, s1_last;

  logic        s2_valid, s2_bad, s2_last, s2_negc, s2_negz;
  logic [41:0] s2_m1, s2_m2;
  trig_t       s2_ring;

  logic                   s3_valid, s3_bad, s3_last;
  logic signed [XY_W-1:0] s3_rc;
  logic signed [Z_W-1:0]  s3_z;
  trig_t                  s3_ring;

  logic                  s4_valid, s4_bad, s4_last, s4_negx, s4_negy;
  logic [42:0]           s4_m3, s4_m4;
  logic signed [Z_W-1:0] s4_z;

  logic                   vo_valid, vo_bad, vo_last;
  logic signed [XY_W-1:0] vo_x, vo_y;
  logic signed [Z_W-1:0]  vo_z;

  logic [RAD_W-1:0] rmaj, rmin;

  function automatic logic [TRIG_W-2:0] trig_mag(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W-1:0] a;
    a = v[TRIG_W-1] ? -v : v;
    return a[TRIG_W-2:0];
  endfunction

  assign rmaj = (major_radius > RADIUS_MAX) ? RADIUS_MAX : major_radius;
  assign rmin = (minor_radius > RADIUS_MAX) ? RADIUS_MAX : minor_radius;

  // whole pipe stalls together behind the output register
  assign en   = !vo_valid || vertex_out.ready;
  assign fire = en && head_valid;
  assign pop  = fire && (head.bad || kcnt == V_DIAG);

  always_comb begin
    case (kcnt)
      V_BASE: begin
        sel_a = head.ring;
        sel_b = head.tube;
      end
      V_RING_NEXT: begin
        sel_a = head.ring_next;
        sel_b = head.tube;
      end
      V_TUBE_NEXT, V_TUBE_NEXT2: begin
        sel_a = head.ring;
        sel_b = head.tube_next;
      end
      V_BASE2: begin
        sel_a = head.ring;
        sel_b = head.tube;
      end
      default: begin
        sel_a = head.ring_prev;
        sel_b = head.tube_next;
      end
    endcase
  end

  assign req.ren       = en;
  assign req.ring_addr = iss_a;
  assign req.tube_addr = iss_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      kcnt      <= V_BASE;
      iss_valid <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      vo_valid  <= 1'b0;
    end else if (en) begin
      iss_valid <= fire;
      if (pop)       kcnt <= V_BASE;
      else if (fire) kcnt <= kcnt + 3'd1;
      s1_valid <= iss_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      vo_valid <= s4_valid;
    end
  end

  logic [42:0]            rnd1, rnd2, rnd3, rnd4;
  logic signed [XY_W-1:0] rc_next;
  logic [XY_W-2:0]        rc_mag;
  logic signed [XY_W-1:0] rc_abs;

  always_comb begin
    rnd1    = 43'(s2_m1) + 43'd32768;
    rnd2    = 43'(s2_m2) + 43'd32768;
    rc_next = s2_negc ? ($signed({2'b00, rmaj}) - $signed({2'b00, rnd1[40:16]}))
                      : ($signed({2'b00, rmaj}) + $signed({2'b00, rnd1[40:16]}));
    rc_abs  = s3_rc[XY_W-1] ? -s3_rc : s3_rc;
    rc_mag  = rc_abs[XY_W-2:0];
    rnd3    = s4_m3 + 43'd32768;
    rnd4    = s4_m4 + 43'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iss_a    <= sel_a;
      iss_b    <= sel_b;
      iss_bad  <= head.bad;
      iss_last <= head.bad || kcnt == V_DIAG;

      s1_bad  <= iss_bad;
      s1_last <= iss_last;

      s2_bad  <= s1_bad;
      s2_last <= s1_last;
      s2_m1   <= 42'(rmin) * 42'(trig_mag(tube_rd.cos_v));
      s2_m2   <= 42'(rmin) * 42'(trig_mag(tube_rd.sin_v));
      s2_negc <= tube_rd.cos_v[TRIG_W-1];
      s2_negz <= tube_rd.sin_v[TRIG_W-1];
      s2_ring <= ring_rd;

      s3_bad  <= s2_bad;
      s3_last <= s2_last;
      s3_rc   <= rc_next;
      s3_z    <= s2_negz ? -$signed({1'b0, rnd2[40:16]}) : $signed({1'b0, rnd2[40:16]});
      s3_ring <= s2_ring;

      s4_bad  <= s3_bad;
      s4_last <= s3_last;
      s4_m3   <= 43'(rc_mag) * 43'(trig_mag(s3_ring.cos_v));
      s4_m4   <= 43'(rc_mag) * 43'(trig_mag(s3_ring.sin_v));
      s4_negx <= s3_rc[XY_W-1] ^ s3_ring.cos_v[TRIG_W-1];
      s4_negy <= s3_rc[XY_W-1] ^ s3_ring.sin_v[TRIG_W-1];
      s4_z    <= s3_z;

      vo_bad  <= s4_bad;
      vo_last <= s4_last;
      if (s4_bad) begin
        vo_x <= '0;
        vo_y <= '0;
        vo_z <= '0;
      end else begin
        vo_x <= s4_negx ? -$signed({1'b0, rnd3[41:16]}) : $signed({1'b0, rnd3[41:16]});
        vo_y <= s4_negy ? -$signed({1'b0, rnd4[41:16]}) : $signed({1'b0, rnd4[41:16]});
        vo_z <= s4_z;
      end
    end
  end

  assign vertex_out.valid       = vo_valid;
  assign vertex_out.vertex_x    = vo_x;
  assign vertex_out.vertex_y    = vo_y;
  assign vertex_out.vertex_z    = vo_z;
  assign vertex_out.bad_cell    = vo_bad;
  assign vertex_out.last_vertex = vo_last;

`ifndef NO_ASSERTIONS
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    vo_valid && vo_bad |-> vo_last && vo_x == '0 && vo_y == '0 && vo_z == '0)
    else $error("bad cell vertex not last or not zero");
  a_pop_end: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && (head.bad || kcnt == V_DIAG))
    else $error("cell popped before its last vertex");
  a_mid_cell: assert property (@(posedge clk) disable iff (rst)
    kcnt != V_BASE |-> head_valid && !head.bad)
    else $error("vertex sequence lost its cell");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(iss_valid) && $stable(s4_valid))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_ttvg_vertex_checker.sv
`timescale 1ns / 100ps
// Vertex checker: predicts six vertices per good cell, one per bad, checks them.
module tb_ttvg_vertex_checker import ttvg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ttvg_cfg_if    cfg,
  ttvg_cell_if   cell_in,
  ttvg_vertex_if vertex_out,
  output int     fail_count,
  output int     pending
);

  typedef struct {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   bad;
    logic                   last;
  } vertex_t;

  vertex_t expected_vertices[$];

  logic [RAD_W-1:0] major_q;
  logic [RAD_W-1:0] minor_q;
  logic [CNT_W-1:0] ring_q;
  logic [CNT_W-1:0] tube_q;

  assign pending = expected_vertices.size();

  // append one vertex at the tail of the expected queue
  task automatic expect_vertex(input vertex_t v);
    expected_vertices = {expected_vertices, v};
  endtask

  // Q16.16 product, round to nearest with ties away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    longint unsigned ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m  = (ua * ub + 64'd32768) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // sine and cosine (Q16.16) of a/n of a full turn
  function automatic void turn_trig(input int unsigned a, input int unsigned n,
                                    output longint s_o, output longint c_o);
    int unsigned sdiv[5] = '{110, 72, 42, 20, 6};
    int unsigned cdiv[6] = '{132, 90, 56, 30, 12, 2};
    longint unsigned one, x, x2, ts, tc;
    int unsigned four, quad, rem;
    logic swap;
    longint s, c, t;
    one  = 64'd1 << 30;
    four = 4 * a;
    quad = four / n;
    rem  = four - quad * n;
    swap = (2 * rem) > n;
    if (swap) rem = n - rem;
    x  = (64'd1686629713 * rem + n / 2) / n;
    x2 = (x * x) >> 30;
    ts = one;
    for (int k = 0; k < 5; k++) ts = one - ((x2 * ts) >> 30) / sdiv[k];
    ts = (x * ts) >> 30;
    tc = one;
    for (int k = 0; k < 6; k++) tc = one - ((x2 * tc) >> 30) / cdiv[k];
    s = longint'((ts + 64'd8192) >> 14);
    c = longint'((tc + 64'd8192) >> 14);
    if (swap) begin
      t = s; s = c; c = t;
    end
    case (quad & 3)
      0:       begin s_o = s;  c_o = c;  end
      1:       begin s_o = c;  c_o = -s; end
      2:       begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s;  end
    endcase
  endfunction

  function automatic vertex_t torus_point(input int unsigned a, input int unsigned na,
                                          input int unsigned b, input int unsigned nb,
                                          input longint big_r, input longint small_r,
                                          input logic last);
    vertex_t v;
    longint st, ct, sp, cp, rc, px, py, pz;
    turn_trig(a, na, st, ct);
    turn_trig(b, nb, sp, cp);
    rc = big_r + fx_mul(small_r, cp);
    px = fx_mul(rc, ct);
    py = fx_mul(rc, st);
    pz = fx_mul(small_r, sp);
    v.x = px[XY_W-1:0];
    v.y = py[XY_W-1:0];
    v.z = pz[Z_W-1:0];
    v.bad = 1'b0;
    v.last = last;
    return v;
  endfunction

  task automatic queue_cell_vertices(input int unsigned i, input int unsigned j);
    int unsigned nr, nt, ip, im, jp;
    longint big_r, small_r;
    vertex_t v;
    nr = (ring_q > MAX_DIVISIONS) ? MAX_DIVISIONS : ring_q;
    nt = (tube_q > MAX_DIVISIONS) ? MAX_DIVISIONS : tube_q;
    big_r   = (major_q > RADIUS_MAX) ? RADIUS_MAX : major_q;
    small_r = (minor_q > RADIUS_MAX) ? RADIUS_MAX : minor_q;
    if (i >= nr || j >= nt) begin
      v.x = '0; v.y = '0; v.z = '0; v.bad = 1'b1; v.last = 1'b1;
      expect_vertex(v);
      return;
    end
    ip = (i + 1 == nr) ? 0 : i + 1;
    im = (i == 0) ? nr - 1 : i - 1;
    jp = (j + 1 == nt) ? 0 : j + 1;
    // two triangles sharing the edge (i,j)-(i,j+1)
    expect_vertex(torus_point(i,  nr, j,  nt, big_r, small_r, 1'b0));
    expect_vertex(torus_point(ip, nr, j,  nt, big_r, small_r, 1'b0));
    expect_vertex(torus_point(i,  nr, jp, nt, big_r, small_r, 1'b0));
    expect_vertex(torus_point(i,  nr, j,  nt, big_r, small_r, 1'b0));
    expect_vertex(torus_point(i,  nr, jp, nt, big_r, small_r, 1'b0));
    expect_vertex(torus_point(im, nr, jp, nt, big_r, small_r, 1'b1));
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      major_q <= MAJOR_RESET;
      minor_q <= MINOR_RESET;
      ring_q  <= RING_RESET;
      tube_q  <= TUBE_RESET;
      expected_vertices.delete();
      fail_count <= 0;
    end else begin
      // predict with the settings in force before this edge
      if (cell_in.valid && cell_in.ready)
        queue_cell_vertices(cell_in.ring_index, cell_in.tube_index);
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAJOR: major_q <= cfg.data;
          REG_MINOR: minor_q <= cfg.data;
          REG_RING:  ring_q  <= cfg.data[CNT_W-1:0];
          REG_TUBE:  tube_q  <= cfg.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (vertex_out.valid && vertex_out.ready) begin
        if (expected_vertices.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected vertex x=%0d y=%0d z=%0d bad=%0b last=%0b",
                     vertex_out.vertex_x, vertex_out.vertex_y, vertex_out.vertex_z,
                     vertex_out.bad_cell, vertex_out.last_vertex);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_vertices.pop_front();
          if (vertex_out.vertex_x !== e.x || vertex_out.vertex_y !== e.y ||
              vertex_out.vertex_z !== e.z || vertex_out.bad_cell !== e.bad ||
              vertex_out.last_vertex !== e.last) begin
            if (fail_count < 10)
              $display("vertex mismatch exp %0d %0d %0d %0b %0b got %0d %0d %0d %0b %0b",
                       e.x, e.y, e.z, e.bad, e.last,
                       vertex_out.vertex_x, vertex_out.vertex_y, vertex_out.vertex_z,
                       vertex_out.bad_cell, vertex_out.last_vertex);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_torus_triangle_vertex_generator_top.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, cell and register stimulus, and the verdict.
module tb_torus_triangle_vertex_generator_top;
  import ttvg_pkg::*;

  // generous: covers table sweeps of 256 divisions plus long output stalls
  localparam int CYCLE_LIMIT = 4000000;
  // slack past the pipeline latency before touching registers
  localparam int SETTLE = 24;

  logic clk;
  logic rst;
  logic quiet;
  int   fail_count;
  int   pending;
  int   cycles;

  ttvg_cfg_if    cfg();
  ttvg_cell_if   cell_in();
  ttvg_vertex_if vertex_out();

  torus_triangle_vertex_generator_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cell_in    (cell_in),
    .vertex_out (vertex_out)
  );

  tb_ttvg_vertex_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cell_in    (cell_in),
    .vertex_out (vertex_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_torus_triangle_vertex_generator_top NOT OK");
      $finish;
    end
  end

  // Vertex sink: random stall bursts, none once quiet is set.
  initial begin
    vertex_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !quiet && $urandom_range(0, 4) == 0) begin
        vertex_out.ready = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        vertex_out.ready = !rst;
      end
    end
  end

  // Drive one cell item; entered and left at a falling edge.
  task automatic send_cell(input int unsigned ri, input int unsigned ti);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cell_in.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    cell_in.valid = 1'b1;
    cell_in.ring_index = IDX_W'(ri);
    cell_in.tube_index = IDX_W'(ti);
    // hold until accepted
    @(posedge clk);
    while (!cell_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Drop valid and wait until every expected vertex is out, plus latency slack.
  task automatic drain;
    cell_in.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all four registers, then send mostly in-range cells.
  task automatic run_phase(input int unsigned big_r, input int unsigned small_r,
                           input int unsigned nr, input int unsigned nt,
                           input int n_items);
    int unsigned er, et, ri, ti;
    write_reg(REG_MAJOR, big_r);
    write_reg(REG_MINOR, small_r);
    write_reg(REG_RING, nr);
    write_reg(REG_TUBE, nt);
    // unused register index: must be ignored
    write_reg(CFG_INDEX_W'($urandom_range(REG_TUBE + 1, 7)), $urandom);
    er = (nr > MAX_DIVISIONS) ? MAX_DIVISIONS : nr;
    et = (nt > MAX_DIVISIONS) ? MAX_DIVISIONS : nt;
    repeat (n_items) begin
      if (er > 0 && et > 0 && $urandom_range(0, 7) != 0) begin
        ri = $urandom_range(0, er - 1);
        ti = $urandom_range(0, et - 1);
      end else begin
        ri = $urandom_range(0, 255);
        ti = $urandom_range(0, 255);
      end
      send_cell(ri, ti);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    cell_in.valid = 1'b0;
    cell_in.ring_index = '0;
    cell_in.tube_index = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed cells on the reset settings (16 x 16): corners, wraps, bad indices.
    send_cell(0, 0);
    send_cell(15, 0);
    send_cell(0, 15);
    send_cell(15, 15);
    send_cell(7, 3);
    send_cell(16, 0);
    send_cell(0, 16);
    send_cell(255, 255);
    send_cell(255, 0);
    send_cell(0, 255);
    send_cell(8, 12);
    send_cell(4, 8);
    drain();

    // Radii above 256.0 saturate; one division each way.
    run_phase(32'h1FFFFFF, 32'h1FFFFFF, 1, 1, 4);
    // Zero radii; zero ring count makes every cell bad.
    run_phase(0, 0, 0, 5, 4);
    // Largest radii, largest ring count, smallest usable tube count.
    run_phase(RADIUS_MAX, RADIUS_MAX, MAX_DIVISIONS, 3, 40);
    // Count above the maximum saturates.
    run_phase($urandom_range(0, 32'h1FFFFFF), $urandom_range(0, 32'h1FFFFFF), 511, 2, 30);

    // Random radii, small counts keep the table sweeps short.
    repeat (7)
      run_phase($urandom_range(0, 32'h1FFFFFF), $urandom_range(0, 32'h1FFFFFF),
                $urandom_range(1, 12), $urandom_range(1, 12), 55);

    // Closing stretch with no idling on either side.
    quiet = 1'b1;
    run_phase($urandom_range(0, RADIUS_MAX), $urandom_range(0, RADIUS_MAX),
              $urandom_range(3, 10), $urandom_range(3, 10), 40);

    if (fail_count == 0)
      $display("tb_torus_triangle_vertex_generator_top OK");
    else
      $display("tb_torus_triangle_vertex_generator_top NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/ttvg_pkg.sv
rtl/ttvg_if.sv
rtl/ttvg_sincos.sv
rtl/ttvg_table.sv
rtl/ttvg_front.sv
rtl/ttvg_back.sv
rtl/torus_triangle_vertex_generator_top.sv
tb/tb_ttvg_vertex_checker.sv
tb/tb_torus_triangle_vertex_generator_top.sv
